FILE: rtl/core/jmhp_pkg.sv
package jmhp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned LimitW   = 12;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned FillW    = 3;

  localparam logic [LimitW-1:0] CommentLimitReset = 12'd2000;
  localparam logic [FillW-1:0]  FillMax           = 3'd6;

  localparam logic [ByteW-1:0] ByteFill   = 8'hFF;
  localparam logic [ByteW-1:0] MarkerSoi  = 8'hD8;
  localparam logic [ByteW-1:0] MarkerSos  = 8'hDA;
  localparam logic [ByteW-1:0] MarkerEoi  = 8'hD9;
  localparam logic [ByteW-1:0] MarkerCom  = 8'hFE;
  localparam logic [ByteW-1:0] ThreeComps = 8'd3;

  localparam logic KindComment = 1'b0;
  localparam logic KindReport  = 1'b1;

  localparam logic [StatusW-1:0] StatusSos      = 3'd0;
  localparam logic [StatusW-1:0] StatusNotJpeg  = 3'd1;
  localparam logic [StatusW-1:0] StatusFill     = 3'd2;
  localparam logic [StatusW-1:0] StatusBadLen   = 3'd3;
  localparam logic [StatusW-1:0] StatusEoi      = 3'd4;
  localparam logic [StatusW-1:0] StatusEarlyEnd = 3'd5;

  typedef struct packed {
    logic               kind;
    logic               comment_first;
    logic [ByteW-1:0]   comment_byte;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    image_height;
    logic [LenW-1:0]    image_width;
    logic               is_color;
    logic [ByteW-1:0]   frame_type;
  } result_t;

  function automatic logic marker_is_frame(input logic [ByteW-1:0] m);
    return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
  endfunction

endpackage

FILE: rtl/core/jmhp_core.sv
module jmhp_core
  import jmhp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              first_byte,
  input  logic              end_of_file,
  input  logic [LimitW-1:0] comment_limit,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [2:0] {
    PH_START_FF,
    PH_START_D8,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t           parse_phase, parse_phase_next;
  logic [FillW-1:0] fill_count, fill_count_next;
  logic [ByteW-1:0] current_marker, current_marker_next;
  logic [LenW-1:0]  segment_length, segment_length_next;
  logic [LenW-1:0]  segment_offset, segment_offset_next;
  logic [LenW-1:0]  stored_height, stored_height_next;
  logic [LenW-1:0]  stored_width, stored_width_next;
  logic             stored_color, stored_color_next;
  logic [ByteW-1:0] stored_frame_code, stored_frame_code_next;
  logic [LenW-1:0]  pend_height, pend_height_next;
  logic [LenW-1:0]  pend_width, pend_width_next;
  logic             pend_color, pend_color_next;

  phase_t           eff_phase;
  logic [LenW:0]    pos_inc;
  logic [LenW-1:0]  len_full;
  logic             is_frame;

  always_comb begin
    eff_phase              = first_byte ? PH_START_FF : parse_phase;
    fill_count_next        = first_byte ? '0 : fill_count;
    current_marker_next    = first_byte ? '0 : current_marker;
    segment_length_next    = first_byte ? '0 : segment_length;
    segment_offset_next    = first_byte ? '0 : segment_offset;
    stored_height_next     = first_byte ? '0 : stored_height;
    stored_width_next      = first_byte ? '0 : stored_width;
    stored_color_next      = first_byte ? 1'b0 : stored_color;
    stored_frame_code_next = first_byte ? '0 : stored_frame_code;
    pend_height_next       = first_byte ? '0 : pend_height;
    pend_width_next        = first_byte ? '0 : pend_width;
    pend_color_next        = first_byte ? 1'b0 : pend_color;
    parse_phase_next       = eff_phase;

    is_frame = marker_is_frame(current_marker_next);
    pos_inc  = {1'b0, segment_offset_next} + {{LenW{1'b0}}, 1'b1};
    len_full = {segment_length_next[LenW-1:ByteW], data_byte};

    res_valid = 1'b0;
    res       = '0;
    res.kind  = KindReport;

    if (end_of_file) begin
      if (eff_phase != PH_DONE) begin
        res_valid        = 1'b1;
        res.status       = StatusEarlyEnd;
        parse_phase_next = PH_DONE;
      end
    end else begin
      case (eff_phase)
        PH_START_FF: begin
          if (data_byte != ByteFill) begin
            res_valid        = 1'b1;
            res.status       = StatusNotJpeg;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = PH_START_D8;
          end
        end
        PH_START_D8: begin
          if (data_byte != MarkerSoi) begin
            res_valid        = 1'b1;
            res.status       = StatusNotJpeg;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = PH_MARKER;
            fill_count_next  = '0;
          end
        end
        PH_MARKER: begin
          if (data_byte == ByteFill) begin
            if (fill_count_next >= FillMax) begin
              res_valid        = 1'b1;
              res.status       = StatusFill;
              parse_phase_next = PH_DONE;
            end else begin
              fill_count_next = fill_count_next + 1'b1;
            end
          end else begin
            current_marker_next = data_byte;
            fill_count_next     = '0;
            parse_phase_next    = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          segment_length_next = {data_byte, {ByteW{1'b0}}};
          parse_phase_next    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          segment_length_next = len_full;
          if (len_full < 16'd2) begin
            res_valid        = 1'b1;
            res.status       = StatusBadLen;
            parse_phase_next = PH_DONE;
          end else if (current_marker_next == MarkerSos) begin
            res_valid        = 1'b1;
            res.status       = StatusSos;
            parse_phase_next = PH_DONE;
          end else if (current_marker_next == MarkerEoi) begin
            res_valid        = 1'b1;
            res.status       = StatusEoi;
            parse_phase_next = PH_DONE;
          end else begin
            segment_offset_next = 16'd2;
            pend_height_next    = '0;
            pend_width_next     = '0;
            pend_color_next     = 1'b0;
            parse_phase_next    = (len_full == 16'd2) ? PH_MARKER : PH_PAYLOAD;
            if (current_marker_next == MarkerCom &&
                (len_full == 16'd2 || comment_limit == '0)) begin
              res_valid         = 1'b1;
              res.kind          = KindComment;
              res.comment_first = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (current_marker_next == MarkerCom) begin
            if ((segment_offset_next - 16'd2) < {{(LenW-LimitW){1'b0}}, comment_limit}) begin
              res_valid         = 1'b1;
              res.kind          = KindComment;
              res.comment_first = (segment_offset_next == 16'd2);
              res.comment_byte  = data_byte;
            end
          end else if (is_frame) begin
            case (segment_offset_next)
              16'd3:   pend_height_next = {data_byte, pend_height_next[ByteW-1:0]};
              16'd4:   pend_height_next = {pend_height_next[LenW-1:ByteW], data_byte};
              16'd5:   pend_width_next  = {data_byte, pend_width_next[ByteW-1:0]};
              16'd6:   pend_width_next  = {pend_width_next[LenW-1:ByteW], data_byte};
              16'd7:   pend_color_next  = (data_byte == ThreeComps);
              default: ;
            endcase
          end
          segment_offset_next = pos_inc[LenW-1:0];
          if (pos_inc >= {1'b0, segment_length_next}) begin
            parse_phase_next = PH_MARKER;
            fill_count_next  = '0;
            if (is_frame && segment_length_next >= 16'd8) begin
              stored_height_next     = pend_height_next;
              stored_width_next      = pend_width_next;
              stored_color_next      = pend_color_next;
              stored_frame_code_next = current_marker_next;
            end
          end
        end
        default: ;
      endcase
    end

    if (res.kind == KindReport) begin
      res.image_height = stored_height_next;
      res.image_width  = stored_width_next;
      res.is_color     = stored_color_next;
      res.frame_type   = stored_frame_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_START_FF;
      fill_count        <= '0;
      current_marker    <= '0;
      segment_length    <= '0;
      segment_offset    <= '0;
      stored_height     <= '0;
      stored_width      <= '0;
      stored_color      <= 1'b0;
      stored_frame_code <= '0;
      pend_height       <= '0;
      pend_width        <= '0;
      pend_color        <= 1'b0;
    end else if (accept) begin
      parse_phase       <= parse_phase_next;
      fill_count        <= fill_count_next;
      current_marker    <= current_marker_next;
      segment_length    <= segment_length_next;
      segment_offset    <= segment_offset_next;
      stored_height     <= stored_height_next;
      stored_width      <= stored_width_next;
      stored_color      <= stored_color_next;
      stored_frame_code <= stored_frame_code_next;
      pend_height       <= pend_height_next;
      pend_width        <= pend_width_next;
      pend_color        <= pend_color_next;
    end
  end

  ap_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillMax)
    else $error("fill count exceeded its bound");

  ap_done_holds: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_DONE) && !(accept && first_byte) |=> (parse_phase == PH_DONE))
    else $error("parser left the done phase without a restart");

  ap_report_done: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && (res.kind == KindReport) |=> (parse_phase == PH_DONE))
    else $error("report given without ending the parse");

endmodule

FILE: rtl/core/jpeg_marker_header_parser_unit.sv
// JPEG marker header parser.
// The input channel (in_valid, in_stall) carries one file byte per transaction,
// with first_byte restarting the parse and end_of_file marking the stream end.
// Each input transaction gives zero or one result on the output channel
// (out_valid, out_stall): either a comment payload byte or a final report with
// status and the frame height, width, color flag and frame code.
// One byte is taken every cycle while in_stall is low. A result is registered
// in the output register, or in the skid register while the output stalls; the
// parse step is a single state update between the parser state registers and
// the output register. When the receiver stalls, one further result is held in a
// skid register and in_stall rises only while that skid register is full, so at
// most two results are buffered. Input transactions that give no result pass
// unaffected by a full output register only while the skid register is empty.
// comment_limit is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while the block is idle, which the block does not enforce. Synchronous
// reset sets comment_limit to 2000, returns the parser to expecting the start
// bytes, clears the stored frame data and empties the output registers.
module jpeg_marker_header_parser_unit
  import jmhp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LimitW-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   data_byte,
  input  logic               first_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic               comment_first,
  output logic [ByteW-1:0]   comment_byte,
  output logic [StatusW-1:0] status,
  output logic [LenW-1:0]    image_height,
  output logic [LenW-1:0]    image_width,
  output logic               is_color,
  output logic [ByteW-1:0]   frame_type
);

  logic [LimitW-1:0] comment_limit;
  logic              skid_valid;
  result_t           out_result;
  result_t           skid_result;
  logic              take;
  logic              out_free;
  logic              res_valid;
  result_t           res;

  assign in_stall = skid_valid;
  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_limit <= CommentLimitReset;
    end else if (cfg_wr_en) begin
      comment_limit <= cfg_wr_data;
    end
  end

  jmhp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (take),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .end_of_file   (end_of_file),
    .comment_limit (comment_limit),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_result <= skid_result;
        out_valid  <= 1'b1;
        skid_valid <= take && res_valid;
        if (take && res_valid) begin
          skid_result <= res;
        end
      end else if (take && res_valid) begin
        out_result <= res;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (take && res_valid) begin
      skid_result <= res;
      skid_valid  <= 1'b1;
    end
  end

  assign result_kind   = out_result.kind;
  assign comment_first = out_result.comment_first;
  assign comment_byte  = out_result.comment_byte;
  assign status        = out_result.status;
  assign image_height  = out_result.image_height;
  assign image_width   = out_result.image_width;
  assign is_color      = out_result.is_color;
  assign frame_type    = out_result.frame_type;

  ap_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register is empty");

  ap_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled while output register was free");

  ap_comment_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.kind == KindComment) |->
      (out_result.status == StatusSos) && (out_result.image_height == '0) &&
      (out_result.frame_type == '0))
    else $error("comment transaction carries report fields");

endmodule

FILE: bench/jmhp_parse_scoreboard.sv
module jmhp_parse_scoreboard
  import jmhp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LimitW-1:0]  cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ByteW-1:0]   data_byte,
  input  logic               first_byte,
  input  logic               end_of_file,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               result_kind,
  input  logic               comment_first,
  input  logic [ByteW-1:0]   comment_byte,
  input  logic [StatusW-1:0] status,
  input  logic [LenW-1:0]    image_height,
  input  logic [LenW-1:0]    image_width,
  input  logic               is_color,
  input  logic [ByteW-1:0]   frame_type,
  output int                 mismatch_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ByteW-1:0] SofFirst   = 8'hC0;
  localparam logic [ByteW-1:0] SofLast    = 8'hCF;
  localparam logic [ByteW-1:0] MarkerDht  = 8'hC4;
  localparam logic [ByteW-1:0] MarkerJpg  = 8'hC8;
  localparam logic [ByteW-1:0] MarkerDac  = 8'hCC;
  localparam logic [LenW-1:0]  LengthSelf = 16'd2;
  localparam logic [LenW-1:0]  FrameMin   = 16'd8;
  localparam int               ShownMax   = 10;

  typedef enum logic [2:0] {
    WaitFf,
    WaitSoi,
    WaitMarker,
    LengthHigh,
    LengthLow,
    InPayload,
    Reported
  } parse_state_t;

  parse_state_t      state;
  logic [LimitW-1:0] comment_limit;
  logic [FillW-1:0]  fill_run;
  logic [ByteW-1:0]  marker;
  logic [LenW-1:0]   seg_len;
  logic [LenW-1:0]   seg_pos;
  logic [LenW-1:0]   frame_height;
  logic [LenW-1:0]   frame_width;
  logic              frame_color;
  logic [ByteW-1:0]  frame_code;
  logic [LenW-1:0]   next_height;
  logic [LenW-1:0]   next_width;
  logic              next_color;
  result_t           expected_q[$];
  result_t           seen;
  result_t           want;
  int                mismatches = 0;

  function automatic logic starts_frame(logic [ByteW-1:0] m);
    return (m >= SofFirst) && (m <= SofLast) &&
           (m != MarkerDht) && (m != MarkerJpg) && (m != MarkerDac);
  endfunction

  function automatic string show(result_t r);
    return {$sformatf("kind %0d first %0d byte %02h status %0d ",
                      r.kind, r.comment_first, r.comment_byte, r.status),
            $sformatf("height %0d width %0d color %0d frame %02h",
                      r.image_height, r.image_width, r.is_color, r.frame_type)};
  endfunction

  task automatic clear_parse();
    state        = WaitFf;
    fill_run     = '0;
    marker       = '0;
    seg_len      = '0;
    seg_pos      = '0;
    frame_height = '0;
    frame_width  = '0;
    frame_color  = 1'b0;
    frame_code   = '0;
    next_height  = '0;
    next_width   = '0;
    next_color   = 1'b0;
  endtask

  task automatic push_report(logic [StatusW-1:0] code);
    result_t r;
    state          = Reported;
    r              = '0;
    r.kind         = KindReport;
    r.status       = code;
    r.image_height = frame_height;
    r.image_width  = frame_width;
    r.is_color     = frame_color;
    r.frame_type   = frame_code;
    expected_q.push_back(r);
  endtask

  task automatic push_comment(logic first, logic [ByteW-1:0] b);
    result_t r;
    r               = '0;
    r.kind          = KindComment;
    r.comment_first = first;
    r.comment_byte  = b;
    expected_q.push_back(r);
  endtask

  task automatic step_parser(input logic [ByteW-1:0] b, input logic restart,
                             input logic stream_end);
    logic [LenW:0] next_pos;
    if (restart) clear_parse();
    if (stream_end) begin
      if (state != Reported) push_report(StatusEarlyEnd);
      return;
    end
    case (state)
      WaitFf: begin
        if (b != ByteFill) push_report(StatusNotJpeg);
        else state = WaitSoi;
      end
      WaitSoi: begin
        if (b != MarkerSoi) begin
          push_report(StatusNotJpeg);
        end else begin
          state    = WaitMarker;
          fill_run = '0;
        end
      end
      WaitMarker: begin
        if (b == ByteFill) begin
          if (fill_run >= FillMax) push_report(StatusFill);
          else fill_run = fill_run + 1'b1;
        end else begin
          marker   = b;
          fill_run = '0;
          state    = LengthHigh;
        end
      end
      LengthHigh: begin
        seg_len = {b, 8'h00};
        state   = LengthLow;
      end
      LengthLow: begin
        seg_len = {seg_len[LenW-1:ByteW], b};
        if (seg_len < LengthSelf) begin
          push_report(StatusBadLen);
        end else if (marker == MarkerSos) begin
          push_report(StatusSos);
        end else if (marker == MarkerEoi) begin
          push_report(StatusEoi);
        end else begin
          seg_pos     = LengthSelf;
          next_height = '0;
          next_width  = '0;
          next_color  = 1'b0;
          state       = (seg_len == LengthSelf) ? WaitMarker : InPayload;
          if (marker == MarkerCom && (seg_len == LengthSelf || comment_limit == '0))
            push_comment(1'b1, 8'h00);
        end
      end
      InPayload: begin
        if (marker == MarkerCom) begin
          if ((seg_pos - LengthSelf) < comment_limit) push_comment(seg_pos == LengthSelf, b);
        end else if (starts_frame(marker)) begin
          case (seg_pos)
            16'd3: next_height = {b, 8'h00};
            16'd4: next_height[ByteW-1:0] = b;
            16'd5: next_width = {b, 8'h00};
            16'd6: next_width[ByteW-1:0] = b;
            16'd7: next_color = (b == ThreeComps);
            default: ;
          endcase
        end
        next_pos = {1'b0, seg_pos} + 1'b1;
        seg_pos  = next_pos[LenW-1:0];
        if (next_pos >= {1'b0, seg_len}) begin
          state    = WaitMarker;
          fill_run = '0;
          if (starts_frame(marker) && seg_len >= FrameMin) begin
            frame_height = next_height;
            frame_width  = next_width;
            frame_color  = next_color;
            frame_code   = marker;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      comment_limit = CommentLimitReset;
      clear_parse();
      expected_q.delete();
    end else begin
      if (cfg_wr_en) comment_limit = cfg_wr_data;
      if (in_valid && !in_stall) step_parser(data_byte, first_byte, end_of_file);
      if (out_valid && !out_stall) begin
        seen = '{result_kind, comment_first, comment_byte, status, image_height,
                 image_width, is_color, frame_type};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMax) $display("Unexpected result: %s", show(seen));
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= ShownMax) begin
              $display("Mismatch, expected %s", show(want));
              $display("          actual   %s", show(seen));
            end
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_q.size();
  end

endmodule

FILE: bench/tb_jpeg_marker_header_parser_unit.sv
module tb_jpeg_marker_header_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jmhp_pkg::*;

  localparam int               HoldCycles    = 80;
  localparam int               WatchdogLimit = 3000;
  localparam int               PhaseItems    = 40;
  localparam int               PhaseCount    = 6;
  localparam logic [ByteW-1:0] SofFirst      = 8'hC0;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             restart;
    logic             stream_end;
  } stream_item_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [LimitW-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   data_byte;
  logic               first_byte;
  logic               end_of_file;
  logic               out_valid;
  logic               out_stall;
  logic               result_kind;
  logic               comment_first;
  logic [ByteW-1:0]   comment_byte;
  logic [StatusW-1:0] status;
  logic [LenW-1:0]    image_height;
  logic [LenW-1:0]    image_width;
  logic               is_color;
  logic [ByteW-1:0]   frame_type;

  int           mismatches;
  int           pending;
  stream_item_t stream_q[$];
  bit           hold_request   = 1'b0;
  bit           sender_idles   = 1'b0;
  bit           receiver_idles = 1'b0;

  jpeg_marker_header_parser_unit i_dut (.*);

  jmhp_parse_scoreboard i_scoreboard (
    .mismatch_count(mismatches),
    .pending_count (pending),
    .*
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom);
  endfunction

  function automatic void put(logic [ByteW-1:0] b);
    stream_q.push_back('{b, 1'b0, 1'b0});
  endfunction

  function automatic void put_restart(logic [ByteW-1:0] b);
    stream_q.push_back('{b, 1'b1, 1'b0});
  endfunction

  function automatic void put_end();
    stream_q.push_back('{rand_byte(), 1'b0, 1'b1});
  endfunction

  function automatic void put_header(logic [ByteW-1:0] m, int fills, logic [LenW-1:0] len);
    repeat (fills) put(ByteFill);
    put(m);
    put(len[LenW-1:ByteW]);
    put(len[ByteW-1:0]);
  endfunction

  function automatic int pick_fills();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 8) return 1;
    return $urandom_range(2, 6);
  endfunction

  function automatic logic [LenW-1:0] pick_dimension();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return LenW'($urandom);
    endcase
  endfunction

  function automatic void put_segment();
    logic [ByteW-1:0] m;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  h;
    logic [LenW-1:0]  w;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      m   = SofFirst + ByteW'($urandom_range(0, 15));
      len = ($urandom_range(0, 4) != 0) ? LenW'($urandom_range(8, 14))
                                        : LenW'($urandom_range(2, 7));
      h   = pick_dimension();
      w   = pick_dimension();
      put_header(m, pick_fills(), len);
      for (int p = 2; p < len; p++) begin
        case (p)
          3: put(h[LenW-1:ByteW]);
          4: put(h[ByteW-1:0]);
          5: put(w[LenW-1:ByteW]);
          6: put(w[ByteW-1:0]);
          7: put($urandom_range(0, 1) ? ThreeComps : rand_byte());
          default: put(rand_byte());
        endcase
      end
    end else if (r < 75) begin
      len = ($urandom_range(0, 4) != 0) ? LenW'($urandom_range(2, 12))
                                        : LenW'($urandom_range(13, 40));
      put_header(MarkerCom, pick_fills(), len);
      for (int p = 2; p < len; p++) put(($urandom_range(0, 4) == 0) ? 8'h00 : rand_byte());
    end else begin
      do m = ByteW'($urandom_range(0, 254)); while (m == MarkerSos || m == MarkerEoi);
      len = LenW'($urandom_range(2, 6));
      put_header(m, pick_fills(), len);
      for (int p = 2; p < len; p++) put(rand_byte());
    end
  endfunction

  function automatic void put_file();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      put_restart(rand_byte());
      repeat ($urandom_range(0, 5)) put(rand_byte());
      if ($urandom_range(0, 1) != 0) put_end();
      return;
    end
    if (r < 9) begin
      stream_q.push_back('{rand_byte(), 1'b1, 1'b1});
      return;
    end
    put_restart(ByteFill);
    put(($urandom_range(0, 29) == 0) ? rand_byte() : MarkerSoi);
    repeat ($urandom_range(0, 4)) put_segment();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      put_header(MarkerSos, pick_fills(), LenW'($urandom_range(2, 12)));
    end else if (r < 60) begin
      put_header(MarkerEoi, pick_fills(), LenW'($urandom_range(2, 12)));
    end else if (r < 80) begin
      put_header(rand_byte(), pick_fills(), LenW'($urandom));
      repeat ($urandom_range(0, 5)) put(rand_byte());
      put_end();
    end else if (r < 90) begin
      repeat (7) put(ByteFill);
    end else begin
      put_header(ByteW'($urandom_range(0, 254)), pick_fills(), LenW'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) put(rand_byte());
      put_end();
    end
  endfunction

  task automatic flush_stream();
    int gap;
    foreach (stream_q[i]) begin
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) >= 60)
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      @(negedge clk);
      in_valid    = 1'b1;
      data_byte   = stream_q[i].data;
      first_byte  = stream_q[i].restart;
      end_of_file = stream_q[i].stream_end;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    stream_q.delete();
  endtask

  task automatic set_comment_limit(logic [LimitW-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        burst        = HoldCycles;
      end else if (burst == 0 && receiver_idles && $urandom_range(0, 99) < 20) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      out_stall = (burst > 0);
      if (burst > 0) burst--;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int               sent;
    logic [LimitW-1:0] next_limit;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    first_byte  = 1'b0;
    end_of_file = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // A stream that ends before any byte, then an end after the report.
    put_end();
    put_end();
    put_restart(8'h00);
    put_restart(ByteFill);
    put(8'h00);
    // Longest legal fill run, an empty comment, a frame of maximum size, then SOS.
    put_restart(ByteFill);
    put(MarkerSoi);
    put_header(MarkerCom, 6, 16'd2);
    put_header(SofFirst, 0, 16'd8);
    put(8'h08);
    put(8'hFF);
    put(8'hFF);
    put(8'hFF);
    put(8'hFF);
    put(ThreeComps);
    put_header(MarkerSos, 0, 16'd2);
    flush_stream();

    // A long comment sent back to back while the receiver holds off.
    hold_request = 1'b1;
    sender_idles = 1'b0;
    put_restart(ByteFill);
    put(MarkerSoi);
    put_header(MarkerCom, 0, 16'd40);
    repeat (38) put(rand_byte());
    put_header(MarkerEoi, 0, 16'd2);
    flush_stream();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        1: next_limit = '0;
        2: next_limit = '1;
        3: next_limit = 12'd1;
        4: next_limit = LimitW'($urandom_range(2, 12));
        default: next_limit = 12'd3;
      endcase
      if (ph > 0) set_comment_limit(next_limit);
      sent = 0;
      while (sent < PhaseItems) begin
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        put_file();
        sent += stream_q.size();
        flush_stream();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
